/* sv/dmr_pkg.sv */
package dmr_pkg;

  localparam int CW = 14;
  localparam int EW = 18;
  localparam int RADW = 8;
  localparam int DIMW = 9;
  localparam int MULW = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] err_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_ADJ,
    ST_WRITE,
    ST_READ,
    ST_RDOUT
  } state_e;

  typedef struct packed {
    logic init;
    logic adj;
    logic next_row;
  } span_ctrl_t;

  typedef struct packed {
    logic settled;
  } span_stat_t;

endpackage

/* sv/dmr_row_mem.sv */
module dmr_row_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dmr_span_unit.sv */
module dmr_span_unit #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                   clk_i,
  input  dmr_pkg::span_ctrl_t    ctrl_i,
  input  logic [7:0]             radius_i,
  input  dmr_pkg::coord_t        dy0_i,
  input  dmr_pkg::coord_t        cx_i,
  input  dmr_pkg::coord_t        w_i,
  output dmr_pkg::span_stat_t    stat_o,
  output logic [MAX_WIDTH-1:0]   row_mask_o
);
  import dmr_pkg::*;

  err_t            e_q, e_d;
  coord_t          dy_q, dy_d;
  logic [RADW-1:0] hw_q, hw_d;

  coord_t                 r_ext, fa, fb, lo, hi;
  logic [2*MULW-1:0]      prod;
  err_t                   g, two_hw_p1, two_hw_m1, two_dy_p1;
  logic                   grow, shrink;

  always_comb begin
    r_ext     = coord_t'(radius_i);
    fa        = r_ext - dy0_i;
    fb        = r_ext + dy0_i;
    prod      = fa[MULW-1:0] * fb[MULW-1:0];
    two_hw_p1 = err_t'({hw_q, 1'b1});
    two_hw_m1 = err_t'({hw_q, 1'b0}) - err_t'(1);
    two_dy_p1 = (err_t'(dy_q) <<< 1) + err_t'(1);
    g         = e_q - two_hw_p1;
    grow      = !g[EW-1] && (hw_q < radius_i);
    shrink    = e_q[EW-1];
    stat_o.settled = !grow && !shrink;

    e_d  = e_q;
    dy_d = dy_q;
    hw_d = hw_q;
    if (ctrl_i.init) begin
      e_d  = $signed({1'b0, prod[EW-2:0]});
      dy_d = dy0_i;
      hw_d = '0;
    end else if (ctrl_i.adj) begin
      if (grow) begin
        e_d  = g;
        hw_d = hw_q + RADW'(1);
      end else if (shrink) begin
        e_d  = e_q + two_hw_m1;
        hw_d = hw_q - RADW'(1);
      end
    end else if (ctrl_i.next_row) begin
      e_d  = e_q - two_dy_p1;
      dy_d = dy_q + coord_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    e_q  <= e_d;
    dy_q <= dy_d;
    hw_q <= hw_d;
  end

  // columns covered by the current half width, clipped to the image
  always_comb begin
    lo = cx_i - coord_t'(hw_q);
    hi = cx_i + coord_t'(hw_q);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_mask_o[i] = (coord_t'(i) >= lo) && (coord_t'(i) <= hi) && (coord_t'(i) < w_i);
    end
  end

endmodule

/* sv/disk_mask_rasterizer.sv */
// clear wipes every row; read fetches one row, then shows the pixel
// draw clips the rows, then per row steps the half width until settled and writes the row
// a draw whose clipped disk holds no row ends after setup
// throughput: one command at a time; the row span unit and the row memory set it
// reset: a clearing pass over all MAX_HEIGHT rows runs while busy_o is high, no result follows it
// each result is shown for one cycle on res_valid_o; the receiver cannot stall
module disk_mask_rasterizer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                cmd_i,
  input  logic signed [9:0]         pos_x_i,
  input  logic signed [9:0]         pos_y_i,
  input  logic [7:0]                radius_i,
  output logic                      res_valid_o,
  output logic                      pixel_o,
  output logic                      done_res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [8:0]                cfg_data_i
);
  import dmr_pkg::*;

  localparam int RAW = $clog2(MAX_HEIGHT);
  localparam int CAW = $clog2(MAX_WIDTH);
  localparam coord_t MaxW = coord_t'(MAX_WIDTH);
  localparam coord_t MaxH = coord_t'(MAX_HEIGHT);

  state_e state_q, state_d;

  logic [DIMW-1:0] wd_q, ht_q;
  coord_t          cx_q, cx_d, cy_q, cy_d, y_q, y_d, y1_q, y1_d;
  logic [RADW-1:0] r_q, r_d;
  logic [RAW-1:0]  row_q, row_d;
  logic            wipe_cmd_q, wipe_cmd_d;
  logic            inb_q, inb_d;
  logic            res_valid_q, res_valid_d, pixel_q, pixel_d, done_q, done_d;

  coord_t w_ext, h_ext, w_eff, h_eff, px_in, py_in, r_ext, y0_c, y1_c, dy0;

  logic                 mem_we;
  logic [RAW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata, row_mask;

  span_ctrl_t span_ctrl;
  span_stat_t span_stat;

  always_comb begin
    w_ext = coord_t'(wd_q);
    h_ext = coord_t'(ht_q);
    w_eff = (w_ext > MaxW) ? MaxW : w_ext;
    h_eff = (h_ext > MaxH) ? MaxH : h_ext;
    px_in = coord_t'(pos_x_i);
    py_in = coord_t'(pos_y_i);
    r_ext = coord_t'(r_q);
    y0_c  = ((cy_q - r_ext) < 0) ? '0 : (cy_q - r_ext);
    y1_c  = ((cy_q + r_ext) > (h_eff - coord_t'(1))) ? (h_eff - coord_t'(1)) : (cy_q + r_ext);
    dy0   = y_q - cy_q;
  end

  dmr_row_mem #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dmr_span_unit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_span (
    .clk_i      (clk_i),
    .ctrl_i     (span_ctrl),
    .radius_i   (r_q),
    .dy0_i      (dy0),
    .cx_i       (cx_q),
    .w_i        (w_eff),
    .stat_o     (span_stat),
    .row_mask_o (row_mask)
  );

  always_comb begin
    state_d     = state_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    r_d         = r_q;
    y_d         = y_q;
    y1_d        = y1_q;
    row_d       = row_q;
    wipe_cmd_d  = wipe_cmd_q;
    inb_d       = inb_q;
    res_valid_d = 1'b0;
    pixel_d     = pixel_q;
    done_d      = done_q;
    mem_we      = 1'b0;
    mem_waddr   = y_q[RAW-1:0];
    mem_wdata   = mem_rdata | row_mask;
    mem_raddr   = y_q[RAW-1:0];
    span_ctrl   = '0;

    case (state_q)
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = row_q;
        mem_wdata = '0;
        row_d     = row_q + RAW'(1);
        if (row_q == RAW'(MAX_HEIGHT - 1)) begin
          row_d       = '0;
          state_d     = ST_IDLE;
          res_valid_d = wipe_cmd_q;
          pixel_d     = 1'b0;
          done_d      = 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cx_d  = px_in;
          cy_d  = py_in;
          r_d   = radius_i;
          inb_d = (px_in >= 0) && (py_in >= 0) && (px_in < w_eff) && (py_in < h_eff);
          case (cmd_i)
            CMD_CLEAR: begin
              wipe_cmd_d = 1'b1;
              row_d      = '0;
              state_d    = ST_WIPE;
            end
            CMD_DRAW: state_d = ST_SETUP;
            CMD_READ: state_d = ST_READ;
            default: begin
              res_valid_d = 1'b1;
              pixel_d     = 1'b0;
              done_d      = 1'b0;
            end
          endcase
        end
      end
      ST_SETUP: begin
        y_d  = y0_c;
        y1_d = y1_c;
        if (y0_c > y1_c) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          pixel_d     = 1'b0;
          done_d      = 1'b1;
        end else begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        span_ctrl.init = 1'b1;
        state_d        = ST_ADJ;
      end
      ST_ADJ: begin
        span_ctrl.adj = 1'b1;
        if (span_stat.settled) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we             = 1'b1;
        span_ctrl.next_row = 1'b1;
        y_d                = y_q + coord_t'(1);
        if (y_q == y1_q) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          pixel_d     = 1'b0;
          done_d      = 1'b1;
        end else begin
          state_d = ST_ADJ;
        end
      end
      ST_READ: begin
        mem_raddr = inb_q ? cy_q[RAW-1:0] : '0;
        state_d   = ST_RDOUT;
      end
      ST_RDOUT: begin
        state_d     = ST_IDLE;
        res_valid_d = 1'b1;
        pixel_d     = inb_q && mem_rdata[cx_q[CAW-1:0]];
        done_d      = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      row_q       <= '0;
      wipe_cmd_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      wipe_cmd_q  <= wipe_cmd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    r_q     <= r_d;
    y_q     <= y_d;
    y1_q    <= y1_d;
    inb_q   <= inb_d;
    pixel_q <= pixel_d;
    done_q  <= done_d;
  end

  // configuration transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q <= DIMW'(256);
      ht_q <= DIMW'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  wd_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: ht_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign pixel_o     = pixel_q;
  assign done_res_o  = done_q;

endmodule

/* sv/dmr_checker.sv */
module dmr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] cmd_i,
  input logic       res_valid_o,
  input logic       pixel_o,
  input logic       done_res_o
);
  import dmr_pkg::*;

  logic start_xfer;
  assign start_xfer = start_i && !busy_o;

  a_work_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_xfer && (cmd_i == CMD_CLEAR || cmd_i == CMD_DRAW || cmd_i == CMD_READ) |=> busy_o)
    else $error("command transfer did not raise busy");

  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_xfer && !(cmd_i == CMD_CLEAR || cmd_i == CMD_DRAW || cmd_i == CMD_READ)
    |=> res_valid_o && !done_res_o && !pixel_o)
    else $error("unused command result wrong");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result shown while busy");

  a_pixel_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !done_res_o |-> !pixel_o)
    else $error("pixel set on result without completion");

endmodule

bind disk_mask_rasterizer dmr_checker u_dmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cmd_i       (cmd_i),
  .res_valid_o (res_valid_o),
  .pixel_o     (pixel_o),
  .done_res_o  (done_res_o)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import dmr_pkg::*;

  localparam int MASK_W = 256;
  localparam int MASK_H = 256;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES = 9;
  localparam int NUM_ROWS = 23;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic pixel;
    logic done;
  } disk_result_t;

  typedef struct {
    logic [1:0] cmd;
    int         x;
    int         y;
    int         r;
    bit         typed;
    bit         pixel;
    bit         done;
  } cmd_row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        cmd_i = CMD_CLEAR;
  logic signed [9:0] pos_x_i = '0;
  logic signed [9:0] pos_y_i = '0;
  logic [7:0]        radius_i = '0;
  logic              res_valid_o;
  logic              pixel_o;
  logic              done_res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = REG_IMAGE_WIDTH;
  logic [8:0]        cfg_data_i = '0;

  bit           mask_mirror [MASK_W*MASK_H];
  logic [8:0]   image_w = 9'd256;
  logic [8:0]   image_h = 9'd256;
  disk_result_t pending_results [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           idle_enable = 1'b1;
  int           last_cx = 0;
  int           last_cy = 0;
  int           last_r = 0;

  cmd_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_READ,     0,    0,   0, 1, 0, 1},
    '{CMD_READ,   255,  255,   0, 1, 0, 1},
    '{CMD_UNUSED,   0,    0,   0, 1, 0, 0},
    '{CMD_DRAW,    10,   10,   0, 1, 0, 1},
    '{CMD_READ,    10,   10,   0, 1, 1, 1},
    '{CMD_READ,    11,   10,   0, 1, 0, 1},
    '{CMD_DRAW,  -256, -256, 255, 1, 0, 1},
    '{CMD_DRAW,   511,  511, 255, 1, 0, 1},
    '{CMD_DRAW,     0,    0,   3, 0, 0, 0},
    '{CMD_READ,    -1,    0,   0, 1, 0, 1},
    '{CMD_READ,     0,   -1,   0, 1, 0, 1},
    '{CMD_READ,     3,    0,   0, 0, 0, 0},
    '{CMD_READ,     2,    2,   0, 0, 0, 0},
    '{CMD_DRAW,   128,  128, 255, 0, 0, 0},
    '{CMD_READ,   255,  255,   0, 0, 0, 0},
    '{CMD_READ,   256,    0,   0, 1, 0, 1},
    '{CMD_READ,   511,  511,   0, 1, 0, 1},
    '{CMD_READ,  -256,    0,   0, 1, 0, 1},
    '{CMD_CLEAR,    0,    0,   0, 1, 0, 1},
    '{CMD_READ,   128,  128,   0, 1, 0, 1},
    '{CMD_DRAW,   255,    0, 255, 0, 0, 0},
    '{CMD_UNUSED, 511, -256, 255, 1, 0, 0},
    '{CMD_READ,   255,    0,   0, 0, 0, 0}
  };

  int phase_w [NUM_PHASES] = '{256, 0, 1, 511, 255, 8, 256, 33, -1};
  int phase_h [NUM_PHASES] = '{256, 40, 1, 257, 0, 200, 256, 511, -1};

  disk_mask_rasterizer #(
    .MAX_WIDTH  (MASK_W),
    .MAX_HEIGHT (MASK_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .radius_i    (radius_i),
    .res_valid_o (res_valid_o),
    .pixel_o     (pixel_o),
    .done_res_o  (done_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic disk_result_t predict_command(logic [1:0] cmd, int x, int y, int r);
    int ew, eh, x0, x1, y0, y1, xx, yy;
    disk_result_t res;
    ew = (image_w > MASK_W) ? MASK_W : int'(image_w);
    eh = (image_h > MASK_H) ? MASK_H : int'(image_h);
    res = '{pixel: 1'b0, done: 1'b1};
    case (cmd)
      CMD_CLEAR: begin
        for (xx = 0; xx < MASK_W*MASK_H; xx++) mask_mirror[xx] = 1'b0;
      end
      CMD_DRAW: begin
        x0 = (x - r < 0) ? 0 : x - r;
        y0 = (y - r < 0) ? 0 : y - r;
        x1 = (x + r > ew - 1) ? ew - 1 : x + r;
        y1 = (y + r > eh - 1) ? eh - 1 : y + r;
        for (yy = y0; yy <= y1; yy++) begin
          for (xx = x0; xx <= x1; xx++) begin
            if ((xx - x) * (xx - x) + (yy - y) * (yy - y) <= r * r)
              mask_mirror[yy*MASK_W + xx] = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (x >= 0 && y >= 0 && x < ew && y < eh) res.pixel = mask_mirror[y*MASK_W + x];
      end
      default: begin
        res.done = 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("%0t ns: %s got %0b expected %0b", $time, what, got, want);
    mismatches++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic program_image(logic [8:0] w, logic [8:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    image_w = w;
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    image_h = h;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic issue_command(logic [1:0] cmd, int x, int y, int r, bit typed,
                               disk_result_t typed_res);
    disk_result_t res;
    start_i  <= 1'b1;
    cmd_i    <= cmd;
    pos_x_i  <= x[9:0];
    pos_y_i  <= y[9:0];
    radius_i <= r[7:0];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    res = predict_command(cmd, x, y, r);
    pending_results.push_back(typed ? typed_res : res);
    if (idle_enable && $urandom_range(0, 99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic int pick_coord(int extent);
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 767)) - 256;
    return int'($urandom_range(0, extent + 16)) - 8;
  endfunction

  function automatic int pick_radius();
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) return $urandom_range(128, 255);
    if (p < 12) return $urandom_range(16, 127);
    return $urandom_range(0, 15);
  endfunction

  function automatic int near_last(int centre);
    return centre + int'($urandom_range(0, 2 * last_r + 4)) - last_r - 2;
  endfunction

  task automatic random_command();
    int p, ew, eh, x, y, r;
    p = $urandom_range(0, 99);
    ew = (image_w > MASK_W) ? MASK_W : int'(image_w);
    eh = (image_h > MASK_H) ? MASK_H : int'(image_h);
    x = 0;
    y = 0;
    r = 0;
    if (p < 3) begin
      issue_command(CMD_CLEAR, x, y, r, 1'b0, '0);
    end else if (p < 40) begin
      x = pick_coord(ew);
      y = pick_coord(eh);
      r = pick_radius();
      last_cx = x;
      last_cy = y;
      last_r = r;
      issue_command(CMD_DRAW, x, y, r, 1'b0, '0);
    end else if (p < 93) begin
      if ($urandom_range(0, 1) == 0) begin
        x = near_last(last_cx);
        y = near_last(last_cy);
        if (x < -256) x = -256;
        if (x > 511) x = 511;
        if (y < -256) y = -256;
        if (y > 511) y = 511;
      end else begin
        x = pick_coord(ew);
        y = pick_coord(eh);
      end
      r = $urandom_range(0, 255);
      issue_command(CMD_READ, x, y, r, 1'b0, '0);
    end else begin
      x = int'($urandom_range(0, 1023)) - 512;
      y = int'($urandom_range(0, 1023)) - 512;
      r = $urandom_range(0, 255);
      issue_command(CMD_UNUSED, x, y, r, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    disk_result_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, pixel", pixel_o, 1'b0);
      end else begin
        want = pending_results.pop_front();
        if (pixel_o !== want.pixel) report_mismatch("pixel", pixel_o, want.pixel);
        if (done_res_o !== want.done) report_mismatch("done_res", done_res_o, want.done);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i, n, w, h;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    for (i = 0; i < NUM_ROWS; i++) begin
      issue_command(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].r, directed_rows[i].typed,
                    '{pixel: directed_rows[i].pixel, done: directed_rows[i].done});
    end

    for (i = 0; i < NUM_PHASES; i++) begin
      wait_drained();
      w = (phase_w[i] < 0) ? $urandom_range(0, 511) : phase_w[i];
      h = (phase_h[i] < 0) ? $urandom_range(0, 511) : phase_h[i];
      program_image(w[8:0], h[8:0]);
      // one phase runs without the random idle gaps between commands
      idle_enable = (i != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_command();
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (1100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
